FILE: hw/rtl/drst_pkg.sv
// Package with shared types and constants for the disjoint range set table.
package drst_pkg;

  localparam int MaxRangesDefault = 64;

  typedef enum logic [3:0] {
    REQ_SET_VALUE   = 4'd0,
    REQ_SET_RANGE   = 4'd1,
    REQ_CLEAR       = 4'd2,
    REQ_MEMBER      = 4'd3,
    REQ_FIRST       = 4'd4,
    REQ_NEXT        = 4'd5,
    REQ_LAST        = 4'd6,
    REQ_PREV        = 4'd7,
    REQ_PREV_MISS   = 4'd8,
    REQ_RSVD9       = 4'd9,
    REQ_RSVD10      = 4'd10,
    REQ_RSVD11      = 4'd11,
    REQ_RSVD12      = 4'd12,
    REQ_RSVD13      = 4'd13,
    REQ_RSVD14      = 4'd14,
    REQ_RSVD15      = 4'd15
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_MV_RD,
    ST_MV_WR,
    ST_WR,
    ST_WR2,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        is_member;
    logic        answer_valid;
    logic [31:0] answer;
    logic        table_full;
  } result_t;

endpackage

FILE: hw/rtl/drst_if.sv
// Valid-ready channel interface carrying one beat of a given payload type.
interface drst_if #(
  parameter type payload_t = logic
) (
  input logic clk
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/drst_ram.sv
// Generic single-port RAM with registered read data.
module drst_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: hw/rtl/disjoint_range_set_table_unit.sv
// Top level of the disjoint range set table with its scan and move sequencer.
// A request walks the stored ranges one at a time: each is read from RAM in ST_SCAN and
// evaluated in ST_EVAL. Moved entries then pass through ST_MV_RD and ST_MV_WR, and table
// writes through ST_WR and ST_WR2. The request ready rises again in the cycle after the
// result beat is taken; no new request is accepted before the previous result is taken.
// Synchronous reset empties the table; range contents are undefined until written.
module disjoint_range_set_table_unit
  import drst_pkg::*;
#(
  parameter int MaxRanges = MaxRangesDefault
) (
  input logic clk,
  input logic rst,
  drst_if.sink   req,
  drst_if.source rsp
);
  localparam int AW = $clog2(MaxRanges);
  localparam int CW = $clog2(MaxRanges + 1);
  localparam logic [CW-1:0] CntMax = CW'(MaxRanges);
  localparam logic [31:0] TopValue = 32'hFFFF_FFFF;

  state_t state, state_next;

  req_t        op;
  logic [31:0] va, vb;
  logic [CW-1:0] cnt, idx, lo, hi;
  logic [31:0] ns, ne;
  logic        lo_found, hi_found;
  logic        found;
  logic        scan_done;
  logic [31:0] res_ans;
  logic        res_valid, res_mem, res_full;
  logic [31:0] pend_s, pend_e;
  logic [CW-1:0] mv_src, mv_dst, mv_left;
  logic        mv_dec;
  logic        wr_pend, wr2_pend;
  logic [CW-1:0] wr_idx;
  logic [31:0] wr_s, wr_e;

  logic        we;
  logic [AW-1:0] addr;
  logic [31:0] ws, wend, rs, re;

  logic        p_full, p_dec, p_wr, p_wr2;
  logic [CW-1:0] p_moves, p_src, p_dst, p_wr_idx, p_cnt;
  logic [31:0] p_wr_s, p_wr_e;
  logic [CW-1:0] ins_l, ins_h, ins_rem;

  drst_ram #(.Width(32), .Depth(MaxRanges)) u_starts (
    .clk(clk), .we(we), .addr(addr), .wdata(ws), .rdata(rs));
  drst_ram #(.Width(32), .Depth(MaxRanges)) u_ends (
    .clk(clk), .we(we), .addr(addr), .wdata(wend), .rdata(re));

  // Scan index for queries that walk down from the top.
  logic        down;
  logic [CW-1:0] ridx;
  assign down = op inside {REQ_LAST, REQ_PREV, REQ_PREV_MISS};
  assign ridx = down ? (cnt - idx - CW'(1)) : idx;

  logic [31:0] va_m1, va_p1, vb_p1;
  assign va_m1 = va - 32'd1;
  assign va_p1 = va + 32'd1;
  assign vb_p1 = vb + 32'd1;

  logic skip, scan_more;
  assign skip = (op == REQ_NEXT && va == TopValue)
             || ((op == REQ_PREV || op == REQ_PREV_MISS) && va == 32'd0)
             || (op == REQ_SET_RANGE && va > vb);
  assign scan_more = !scan_done && !skip && (idx < cnt);

  assign ins_l = lo_found ? lo : cnt;
  assign ins_h = hi_found ? hi : cnt;
  assign ins_rem = ins_h - ins_l;

  // Table update planned once the scan is over.
  always_comb begin
    p_full = 1'b0;
    p_moves = '0;
    p_src = '0;
    p_dst = '0;
    p_dec = 1'b0;
    p_wr = 1'b0;
    p_wr2 = 1'b0;
    p_wr_idx = '0;
    p_wr_s = ns;
    p_wr_e = ne;
    p_cnt = cnt;
    unique case (op) inside
      REQ_SET_VALUE, REQ_SET_RANGE: begin
        if (!skip) begin
          if (ins_rem == '0 && cnt == CntMax) begin
            p_full = 1'b1;
          end else begin
            p_wr = 1'b1;
            p_wr_idx = ins_l;
            p_cnt = cnt - ins_rem + CW'(1);
            if (ins_rem == '0) begin
              p_moves = cnt - ins_l;
              p_src = cnt - CW'(1);
              p_dst = cnt;
              p_dec = 1'b1;
            end else if (ins_rem > CW'(1)) begin
              p_moves = cnt - ins_h;
              p_src = ins_h;
              p_dst = ins_l + CW'(1);
            end
          end
        end
      end
      REQ_CLEAR: begin
        if (found) begin
          if (pend_s == va && pend_e == va) begin
            p_moves = cnt - lo - CW'(1);
            p_src = lo + CW'(1);
            p_dst = lo;
            p_cnt = cnt - CW'(1);
          end else if (pend_s == va) begin
            p_wr = 1'b1;
            p_wr_idx = lo;
            p_wr_s = va_p1;
            p_wr_e = pend_e;
          end else if (pend_e == va) begin
            p_wr = 1'b1;
            p_wr_idx = lo;
            p_wr_s = pend_s;
            p_wr_e = va_m1;
          end else if (cnt == CntMax) begin
            p_full = 1'b1;
          end else begin
            p_moves = cnt - lo - CW'(1);
            p_src = cnt - CW'(1);
            p_dst = cnt;
            p_dec = 1'b1;
            p_wr = 1'b1;
            p_wr2 = 1'b1;
            p_wr_idx = lo + CW'(1);
            p_wr_s = va_p1;
            p_wr_e = pend_e;
            p_cnt = cnt + CW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req.valid && req.ready) state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_more) state_next = ST_EVAL;
        else if (p_full) state_next = ST_OUT;
        else if (p_moves != '0) state_next = ST_MV_RD;
        else if (p_wr) state_next = ST_WR;
        else state_next = ST_OUT;
      end
      ST_EVAL:  state_next = ST_SCAN;
      ST_MV_RD: state_next = ST_MV_WR;
      ST_MV_WR: begin
        if (mv_left != CW'(1)) state_next = ST_MV_RD;
        else if (wr_pend) state_next = ST_WR;
        else state_next = ST_OUT;
      end
      ST_WR:    state_next = wr2_pend ? ST_WR2 : ST_OUT;
      ST_WR2:   state_next = ST_OUT;
      ST_OUT:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == ST_IDLE) && !rsp.valid;
    we = 1'b0;
    addr = ridx[AW-1:0];
    ws = wr_s;
    wend = wr_e;
    unique case (state)
      ST_MV_RD: addr = mv_src[AW-1:0];
      ST_MV_WR: begin
        we = 1'b1;
        addr = mv_dst[AW-1:0];
        ws = rs;
        wend = re;
      end
      ST_WR: begin
        we = 1'b1;
        addr = wr_idx[AW-1:0];
      end
      ST_WR2: begin
        we = 1'b1;
        addr = lo[AW-1:0];
        ws = pend_s;
        wend = va_m1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_OUT) rsp.valid <= 1'b1;
      else if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (req.valid && req.ready) begin
            op <= req.data.req_type;
            va <= req.data.value;
            vb <= (req.data.req_type == REQ_SET_VALUE) ? req.data.value : req.data.range_end;
            idx <= '0;
            lo_found <= 1'b0;
            hi_found <= 1'b0;
            found <= 1'b0;
            scan_done <= 1'b0;
            res_ans <= '0;
            res_valid <= 1'b0;
            res_mem <= 1'b0;
            res_full <= 1'b0;
            ns <= req.data.value;
            ne <= (req.data.req_type == REQ_SET_VALUE) ? req.data.value
                                                        : req.data.range_end;
          end
        end
        ST_SCAN: begin
          if (!scan_more) begin
            res_full <= p_full;
            cnt <= p_cnt;
            mv_src <= p_src;
            mv_dst <= p_dst;
            mv_left <= p_moves;
            mv_dec <= p_dec;
            wr_pend <= p_wr;
            wr2_pend <= p_wr2;
            wr_idx <= p_wr_idx;
            wr_s <= p_wr_s;
            wr_e <= p_wr_e;
            if (op == REQ_MEMBER) res_mem <= found;
            if (op == REQ_PREV_MISS && va != 32'd0 && !scan_done) begin
              res_valid <= 1'b1;
              res_ans <= va_m1;
            end
          end
        end
        ST_EVAL: begin
          idx <= idx + CW'(1);
          unique case (op) inside
            REQ_SET_VALUE, REQ_SET_RANGE: begin
              if (!lo_found) begin
                if (va == 32'd0 || re >= va_m1) begin
                  lo_found <= 1'b1;
                  lo <= idx;
                  if (vb == TopValue || rs <= vb_p1) begin
                    if (rs < ns) ns <= rs;
                    if (re > ne) ne <= re;
                  end else begin
                    hi_found <= 1'b1;
                    hi <= idx;
                    scan_done <= 1'b1;
                  end
                end
              end else if (vb == TopValue || rs <= vb_p1) begin
                if (rs < ns) ns <= rs;
                if (re > ne) ne <= re;
              end else begin
                hi_found <= 1'b1;
                hi <= idx;
                scan_done <= 1'b1;
              end
            end
            REQ_CLEAR, REQ_MEMBER: begin
              if (rs <= va && va <= re) begin
                found <= 1'b1;
                lo <= idx;
                pend_s <= rs;
                pend_e <= re;
                scan_done <= 1'b1;
              end
            end
            REQ_FIRST: begin
              res_valid <= 1'b1;
              res_ans <= rs;
              scan_done <= 1'b1;
            end
            REQ_LAST: begin
              res_valid <= 1'b1;
              res_ans <= re;
              scan_done <= 1'b1;
            end
            REQ_NEXT: begin
              if (rs > va) begin
                res_valid <= 1'b1; res_ans <= rs; scan_done <= 1'b1;
              end else if (rs <= va_p1 && va_p1 <= re) begin
                res_valid <= 1'b1; res_ans <= va_p1; scan_done <= 1'b1;
              end
            end
            REQ_PREV: begin
              if (re < va) begin
                res_valid <= 1'b1; res_ans <= re; scan_done <= 1'b1;
              end else if (rs <= va_m1 && va_m1 <= re) begin
                res_valid <= 1'b1; res_ans <= va_m1; scan_done <= 1'b1;
              end
            end
            REQ_PREV_MISS: begin
              if ((rs <= va && va <= re) || (va > re && va == re + 32'd1)) begin
                res_valid <= (rs != 32'd0);
                res_ans <= (rs != 32'd0) ? rs - 32'd1 : 32'd0;
                scan_done <= 1'b1;
              end else if (va > re) begin
                res_valid <= 1'b1; res_ans <= va_m1; scan_done <= 1'b1;
              end
            end
            default: scan_done <= 1'b1;
          endcase
        end
        ST_MV_WR: begin
          mv_left <= mv_left - CW'(1);
          if (mv_dec) begin
            mv_src <= mv_src - CW'(1);
            mv_dst <= mv_dst - CW'(1);
          end else begin
            mv_src <= mv_src + CW'(1);
            mv_dst <= mv_dst + CW'(1);
          end
        end
        ST_OUT: begin
          rsp.data.is_member <= res_mem;
          rsp.data.answer_valid <= res_valid;
          rsp.data.answer <= res_valid ? res_ans : 32'd0;
          rsp.data.table_full <= res_full;
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: bench/tb.sv
// Self-checking bench for the range set table: queue-fed driver, predicting monitor.
module tb;
  import drst_pkg::*;

  typedef struct packed {
    req_t        req_type;
    logic [31:0] value;
    logic [31:0] range_end;
  } req_beat_t;

  typedef struct {
    req_beat_t beat;
    int        phase;
    bit        drain;
    bit        hold;
  } pending_t;

  localparam int NumRanges = MaxRangesDefault;
  localparam int WatchLimit = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  drst_if #(.payload_t(req_beat_t)) req (.clk(clk));
  drst_if #(.payload_t(result_t)) rsp (.clk(clk));

  disjoint_range_set_table_unit dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always #2 clk = ~clk;

  pending_t  pending_q[$];
  result_t   expected_q[$];
  bit [31:0] tbl_start[NumRanges + 2];
  bit [31:0] tbl_end[NumRanges + 2];
  int        tbl_count = 0;
  int        errors = 0;
  int        cur_phase;
  logic      hold_trig;
  logic      hold_seen;
  int        hold_cnt;
  int        quiet_cycles;

  function automatic int find_slot(bit [31:0] v);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_start[i] <= v && v <= tbl_end[i]) return i;
    end
    return -1;
  endfunction

  function automatic bit insert_span(bit [31:0] a, bit [31:0] b);
    int lo, hi, removed, newcount;
    bit [31:0] ns, ne;
    lo = 0;
    ns = a;
    ne = b;
    while (lo < tbl_count && a > 0 && tbl_end[lo] < a - 1) lo++;
    hi = lo;
    while (hi < tbl_count && (b == 32'hFFFF_FFFF || tbl_start[hi] <= b + 1)) begin
      if (tbl_start[hi] < ns) ns = tbl_start[hi];
      if (tbl_end[hi] > ne) ne = tbl_end[hi];
      hi++;
    end
    removed = hi - lo;
    newcount = tbl_count - removed + 1;
    if (newcount > NumRanges) return 1'b0;
    if (removed == 0) begin
      for (int k = tbl_count - 1; k >= lo; k--) begin
        tbl_start[k + 1] = tbl_start[k];
        tbl_end[k + 1] = tbl_end[k];
      end
    end else if (removed > 1) begin
      for (int k = hi; k < tbl_count; k++) begin
        tbl_start[lo + 1 + k - hi] = tbl_start[k];
        tbl_end[lo + 1 + k - hi] = tbl_end[k];
      end
    end
    tbl_start[lo] = ns;
    tbl_end[lo] = ne;
    tbl_count = newcount;
    return 1'b1;
  endfunction

  function automatic bit clear_value(bit [31:0] v);
    int f;
    f = find_slot(v);
    if (f < 0) return 1'b1;
    if (tbl_start[f] == v && tbl_end[f] == v) begin
      for (int k = f; k < tbl_count - 1; k++) begin
        tbl_start[k] = tbl_start[k + 1];
        tbl_end[k] = tbl_end[k + 1];
      end
      tbl_count--;
    end else if (tbl_start[f] == v) begin
      tbl_start[f] = v + 1;
    end else if (tbl_end[f] == v) begin
      tbl_end[f] = v - 1;
    end else begin
      if (tbl_count >= NumRanges) return 1'b0;
      for (int k = tbl_count - 1; k > f; k--) begin
        tbl_start[k + 1] = tbl_start[k];
        tbl_end[k + 1] = tbl_end[k];
      end
      tbl_start[f + 1] = v + 1;
      tbl_end[f + 1] = tbl_end[f];
      tbl_end[f] = v - 1;
      tbl_count++;
    end
    return 1'b1;
  endfunction

  function automatic result_t predict_result(req_beat_t b);
    result_t r;
    bit [31:0] v;
    bit done;
    r = '0;
    v = b.value;
    done = 1'b0;
    case (b.req_type)
      REQ_SET_VALUE: r.table_full = !insert_span(v, v);
      REQ_SET_RANGE: if (v <= b.range_end) r.table_full = !insert_span(v, b.range_end);
      REQ_CLEAR: r.table_full = !clear_value(v);
      REQ_MEMBER: r.is_member = find_slot(v) >= 0;
      REQ_FIRST: if (tbl_count > 0) begin
        r.answer_valid = 1'b1;
        r.answer = tbl_start[0];
      end
      REQ_LAST: if (tbl_count > 0) begin
        r.answer_valid = 1'b1;
        r.answer = tbl_end[tbl_count - 1];
      end
      REQ_NEXT: if (v != 32'hFFFF_FFFF) begin
        for (int i = 0; i < tbl_count && !done; i++) begin
          if (tbl_start[i] > v) begin
            r.answer = tbl_start[i];
            done = 1'b1;
          end else if (tbl_start[i] <= v + 1 && v + 1 <= tbl_end[i]) begin
            r.answer = v + 1;
            done = 1'b1;
          end
        end
        r.answer_valid = done;
      end
      REQ_PREV: if (v != 0) begin
        for (int i = tbl_count - 1; i >= 0 && !done; i--) begin
          if (tbl_end[i] < v) begin
            r.answer = tbl_end[i];
            done = 1'b1;
          end else if (tbl_start[i] <= v - 1 && v - 1 <= tbl_end[i]) begin
            r.answer = v - 1;
            done = 1'b1;
          end
        end
        r.answer_valid = done;
      end
      REQ_PREV_MISS: if (v != 0) begin
        r.answer_valid = 1'b1;
        r.answer = v - 1;
        for (int i = tbl_count - 1; i >= 0 && !done; i--) begin
          if ((tbl_start[i] <= v && v <= tbl_end[i]) || (v > tbl_end[i] && v == tbl_end[i] + 1))
          begin
            done = 1'b1;
            if (tbl_start[i] == 0) r.answer_valid = 1'b0;
            else r.answer = tbl_start[i] - 1;
          end else if (v > tbl_end[i]) begin
            done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (!r.answer_valid) r.answer = '0;
    return r;
  endfunction

  function automatic int pct(int phase, bit receiver);
    case (phase)
      1: return receiver ? 0 : 66;
      2: return receiver ? 66 : 0;
      3: return 32;
      default: return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.data <= '0;
      cur_phase <= 0;
      hold_trig <= 1'b0;
    end else if (!req.valid || req.ready) begin
      if (pending_q.size() > 0 &&
          !(pending_q[0].drain && (req.valid || expected_q.size() > 0)) &&
          $urandom_range(99) >= pct(pending_q[0].phase, 1'b0)) begin
        req.valid <= 1'b1;
        req.data <= pending_q[0].beat;
        cur_phase <= pending_q[0].phase;
        if (pending_q[0].hold) hold_trig <= ~hold_trig;
        void'(pending_q.pop_front());
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      hold_cnt <= 0;
      hold_seen <= 1'b0;
    end else if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_cnt <= 400;
      rsp.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= $urandom_range(99) >= pct(cur_phase, 1'b1);
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (req.valid && req.ready) expected_q.push_back(predict_result(req.data));
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected beat, actual %h", $time, rsp.data);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.is_member !== rsp.data.is_member ||
              exp_r.answer_valid !== rsp.data.answer_valid ||
              exp_r.answer !== rsp.data.answer ||
              exp_r.table_full !== rsp.data.table_full) begin
            $display("%0t: expected m=%b v=%b a=%h f=%b, actual m=%b v=%b a=%h f=%b", $time,
                     exp_r.is_member, exp_r.answer_valid, exp_r.answer, exp_r.table_full,
                     rsp.data.is_member, rsp.data.answer_valid, rsp.data.answer,
                     rsp.data.table_full);
            errors++;
          end
        end
      end
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("disjoint_range_set_table_unit: mismatch");
        $finish;
      end
    end
  end

  task automatic add_item(req_t t, bit [31:0] v, bit [31:0] e, int phase, bit drain, bit hold);
    pending_t p;
    p.beat.req_type = t;
    p.beat.value = v;
    p.beat.range_end = e;
    p.phase = phase;
    p.drain = drain;
    p.hold = hold;
    pending_q.push_back(p);
  endtask

  task automatic add_random(int phase, bit [31:0] base);
    int sel;
    bit [31:0] v, e;
    req_t t;
    sel = $urandom_range(99);
    v = base + $urandom_range(260);
    if (sel < 30) begin
      t = REQ_SET_VALUE;
      v = base + 2 * $urandom_range(110);
    end else if (sel < 38) t = REQ_SET_RANGE;
    else if (sel < 52) t = REQ_CLEAR;
    else if (sel < 94) t = req_t'($urandom_range(REQ_MEMBER, REQ_PREV_MISS));
    else begin
      t = req_t'($urandom_range(15));
      v = $urandom;
    end
    e = v + $urandom_range(12);
    if ($urandom_range(9) == 0) e = $urandom;
    add_item(t, v, e, phase, 1'b0, 1'b0);
  endtask

  initial begin
    bit [31:0] base;
    int hold_at;

    add_item(REQ_FIRST, 0, 0, 0, 0, 0);
    add_item(REQ_LAST, 0, 0, 0, 0, 0);
    add_item(REQ_PREV, 0, 0, 0, 0, 0);
    add_item(REQ_PREV_MISS, 0, 0, 0, 0, 0);
    add_item(REQ_NEXT, 32'hFFFF_FFFF, 0, 0, 0, 0);
    add_item(REQ_SET_VALUE, 0, 0, 0, 0, 0);
    add_item(REQ_SET_VALUE, 0, 0, 0, 0, 0);
    add_item(REQ_PREV_MISS, 1, 0, 0, 0, 0);
    add_item(REQ_SET_VALUE, 32'hFFFF_FFFF, 0, 0, 0, 0);
    add_item(REQ_NEXT, 32'hFFFF_FFFE, 0, 0, 0, 0);
    add_item(REQ_SET_RANGE, 100, 50, 0, 0, 0);
    add_item(REQ_SET_RANGE, 10, 20, 0, 0, 0);
    add_item(REQ_SET_RANGE, 21, 30, 0, 0, 0);
    add_item(REQ_PREV_MISS, 100, 0, 0, 0, 0);
    add_item(REQ_PREV_MISS, 25, 0, 0, 0, 0);
    add_item(REQ_CLEAR, 15, 0, 0, 0, 0);
    add_item(REQ_CLEAR, 500, 0, 0, 0, 0);
    add_item(REQ_MEMBER, 15, 0, 0, 0, 0);
    add_item(REQ_MEMBER, 16, 0, 0, 0, 0);
    add_item(REQ_PREV, 32'hFFFF_FFFF, 0, 0, 0, 0);
    add_item(REQ_RSVD12, 7, 7, 0, 0, 0);
    add_item(REQ_SET_RANGE, 0, 32'hFFFF_FFFF, 0, 0, 0);
    add_item(REQ_CLEAR, 32'h8000_0000, 0, 0, 0, 0);
    add_item(REQ_LAST, 0, 0, 0, 0, 0);
    add_item(REQ_SET_RANGE, 1, 32'hFFFF_FFFE, 0, 1, 0);

    for (int ph = 0; ph < 4; ph++) begin
      hold_at = $urandom_range(100, 250);
      for (int n = 0; n < 300; n++) begin
        if (n % 125 == 0) begin
          case ($urandom_range(2))
            0: base = 0;
            1: base = 32'hFFFF_FEF0;
            default: base = $urandom;
          endcase
          if (base > 32'hFFFF_FEF0) base = 32'hFFFF_FEF0;
          add_item(REQ_SET_RANGE, 0, 32'hFFFF_FFFF, ph, 1'b1, 1'b0);
          add_item(REQ_CLEAR, base + 300, 0, ph, 1'b0, 1'b0);
          add_item(REQ_CLEAR, 32'hFFFF_FFFF, 0, ph, 1'b0, 1'b0);
          add_item(REQ_CLEAR, 0, 0, ph, 1'b0, 1'b0);
          for (int k = 0; k < 300 && base > 0; k += 4) add_item(REQ_CLEAR, k, 0, ph, 0, 0);
        end
        if (n == hold_at) add_item(REQ_MEMBER, base, 0, ph, 1'b0, 1'b1);
        else add_random(ph, base);
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (pending_q.size() > 0 || req.valid || expected_q.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("disjoint_range_set_table_unit: match");
    end else begin
      $display("disjoint_range_set_table_unit: mismatch");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hw/rtl/drst_pkg.sv
hw/rtl/drst_if.sv
hw/rtl/drst_ram.sv
hw/rtl/disjoint_range_set_table_unit.sv
bench/tb.sv
